@@ rtl/sts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and helpers of the S-expression token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int POS_W      = 24;  // width of the byte position counter
  localparam int TOK_POS_W  = 24;  // width of the start field
  localparam int TOK_LEN_W  = 24;
  localparam int VALUE_W    = 31;
  localparam int NUM_SLOTS  = 3;   // most tokens one request can cause
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [TOK_LEN_W-1:0] LEN_MAX   = '1;
  localparam logic [VALUE_W-1:0]   VALUE_MAX = '1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NUM     = 2'd1,
    MODE_ID      = 2'd2,
    MODE_COMMENT = 2'd3
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_END        = 3'd0,
    KIND_LPAREN     = 3'd1,
    KIND_RPAREN     = 3'd2,
    KIND_PLUS       = 3'd3,
    KIND_MINUS      = 3'd4,
    KIND_NUMBER     = 3'd5,
    KIND_IDENT      = 3'd6,
    KIND_UNEXPECTED = 3'd7
  } token_kind_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [TOK_POS_W-1:0]   start;
    logic [TOK_LEN_W-1:0]   length;
    logic [VALUE_W-1:0]     value;
    logic                   overflow;
  } token_t;

  // Slot 0: token closed by the byte, slot 1: byte token or final flush,
  // slot 2: end-of-text token.
  typedef struct packed {
    logic   [NUM_SLOTS-1:0] slot_vld;
    token_t [NUM_SLOTS-1:0] tok;
  } bundle_t;

  function automatic token_t mk_tok(token_kind_t kind, logic [POS_W-1:0] pos,
                                    logic [TOK_LEN_W-1:0] len,
                                    logic [VALUE_W-1:0] value, logic ovf);
    token_t t;
    t.kind     = kind;
    t.start    = TOK_POS_W'(pos);
    t.length   = len;
    t.value    = value;
    t.overflow = ovf;
    return t;
  endfunction

endpackage

@@ rtl/sts_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Classifies each text byte, tracks the pending token and builds the bundle
// of tokens that the request causes.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_take,
  input  logic [7:0] text_byte,
  input  logic       byte_valid,
  input  logic       end_of_input,
  output logic       push,
  output bundle_t    push_data
);

  scan_mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       pstart_r, pstart_nxt;
  logic [TOK_LEN_W-1:0]   plen_r, plen_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   is_digit, is_letter, is_ident, is_space;
  logic [3:0]             digit_val;
  logic [VALUE_W+3:0]     acc_prod;
  logic [TOK_LEN_W-1:0]   plen_ext;
  logic                   done;
  bundle_t                bnd;

  assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_letter = ((text_byte >= CH_LOWER_A) && (text_byte <= CH_LOWER_Z)) ||
                     ((text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z));
  assign is_ident  = is_letter || is_digit || (text_byte == CH_UNDER);
  assign is_space  = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                     (text_byte == CH_NL);

  assign digit_val = 4'(text_byte - CH_ZERO);
  // acc * 10 + digit as two shifts and adds
  assign acc_prod  = ((VALUE_W+4)'(acc_r) << 3) + ((VALUE_W+4)'(acc_r) << 1) +
                     (VALUE_W+4)'(digit_val);
  assign plen_ext  = (plen_r == LEN_MAX) ? plen_r : plen_r + 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    done       = 1'b0;
    bnd        = '0;

    if (byte_valid) begin
      case (mode_r)
        MODE_NUM: begin
          if (is_digit) begin
            plen_nxt = plen_ext;
            if (acc_prod > (VALUE_W+4)'(VALUE_MAX)) begin
              acc_nxt = VALUE_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = VALUE_W'(acc_prod);
            end
            done = 1'b1;
          end else begin
            bnd.slot_vld[0] = 1'b1;
            bnd.tok[0] = mk_tok(KIND_NUMBER, pstart_r, plen_r, acc_r, ovf_r);
            mode_nxt = MODE_IDLE;
            plen_nxt = '0;
            acc_nxt  = '0;
            ovf_nxt  = 1'b0;
          end
        end
        MODE_ID: begin
          if (is_ident) begin
            plen_nxt = plen_ext;
            done = 1'b1;
          end else begin
            bnd.slot_vld[0] = 1'b1;
            bnd.tok[0] = mk_tok(KIND_IDENT, pstart_r, plen_r, '0, 1'b0);
            mode_nxt = MODE_IDLE;
            plen_nxt = '0;
            acc_nxt  = '0;
            ovf_nxt  = 1'b0;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
          done = 1'b1;
        end
        default: begin
          done = 1'b0;
        end
      endcase

      if (!done) begin
        if (is_space) begin
          bnd.slot_vld[1] = 1'b0;
        end else if (text_byte == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (is_digit) begin
          mode_nxt   = MODE_NUM;
          pstart_nxt = pos_r;
          plen_nxt   = TOK_LEN_W'(1);
          acc_nxt    = VALUE_W'(digit_val);
          ovf_nxt    = 1'b0;
        end else if (is_letter) begin
          mode_nxt   = MODE_ID;
          pstart_nxt = pos_r;
          plen_nxt   = TOK_LEN_W'(1);
          acc_nxt    = '0;
          ovf_nxt    = 1'b0;
        end else begin
          bnd.slot_vld[1] = 1'b1;
          case (text_byte)
            CH_NUL:    bnd.tok[1] = mk_tok(KIND_END, pos_r, TOK_LEN_W'(1), '0, 1'b0);
            CH_LPAREN: bnd.tok[1] = mk_tok(KIND_LPAREN, pos_r, TOK_LEN_W'(1), '0, 1'b0);
            CH_RPAREN: bnd.tok[1] = mk_tok(KIND_RPAREN, pos_r, TOK_LEN_W'(1), '0, 1'b0);
            CH_PLUS:   bnd.tok[1] = mk_tok(KIND_PLUS, pos_r, TOK_LEN_W'(1), '0, 1'b0);
            CH_MINUS:  bnd.tok[1] = mk_tok(KIND_MINUS, pos_r, TOK_LEN_W'(1), '0, 1'b0);
            default:   bnd.tok[1] = mk_tok(KIND_UNEXPECTED, pos_r, TOK_LEN_W'(1), '0,
                                           1'b0);
          endcase
        end
      end
      pos_nxt = pos_r + 1'b1;
    end

    if (end_of_input) begin
      // a byte token leaves the scanner idle, so the flush never clashes
      if (mode_nxt == MODE_NUM) begin
        bnd.slot_vld[1] = 1'b1;
        bnd.tok[1] = mk_tok(KIND_NUMBER, pstart_nxt, plen_nxt, acc_nxt, ovf_nxt);
      end else if (mode_nxt == MODE_ID) begin
        bnd.slot_vld[1] = 1'b1;
        bnd.tok[1] = mk_tok(KIND_IDENT, pstart_nxt, plen_nxt, '0, 1'b0);
      end
      bnd.slot_vld[2] = 1'b1;
      bnd.tok[2] = mk_tok(KIND_END, pos_nxt, TOK_LEN_W'(1), '0, 1'b0);
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      pstart_nxt = '0;
      plen_nxt   = '0;
      acc_nxt    = '0;
      ovf_nxt    = 1'b0;
    end
  end

  assign push      = req_take && (|bnd.slot_vld);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (req_take) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

@@ rtl/sts_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_fifo
// Short queue of token bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module sts_fifo import sts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    empty,
  output logic    full,
  output bundle_t head
);

  bundle_t              entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/sts_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_back
// Walks the present slots of the head bundle and hands out one token per
// cycle through the output register while out_stall is low.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     empty,
  input  bundle_t  head,
  output logic     pop,
  input  logic     out_stall,
  output logic     out_valid,
  output token_t   out_tok,
  output logic     out_last
);

  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 valid_r;
  token_t               tok_r;
  logic                 last_r;

  logic [NUM_SLOTS-1:0] avail;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    sel;
  logic                 sel_last;
  logic                 load;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      avail[i] = head.slot_vld[i] && (SLOT_W'(i) >= slot_r);
    end
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        sel = SLOT_W'(i);
      end
    end
    rest = avail;
    rest[sel] = 1'b0;
    sel_last = (rest == '0);
  end

  assign load     = !empty && (!valid_r || !out_stall);
  assign pop      = load && sel_last;
  assign slot_nxt = sel_last ? '0 : sel + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        slot_r  <= slot_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.tok[sel];
      last_r <= sel_last;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

@@ rtl/sexpr_token_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// Streaming tokenizer for S-expression text: one byte in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per request,
//   with in_byte_valid for a byte and in_end_of_input on the final request.
//   Output channel (out_valid / out_stall) gives one token per transfer;
//   out_last_of_run marks the last token caused by a request.
//   A request's tokens go into the bundle queue at the edge that takes the
//   request and then through the output register that drives out_valid.
//   Throughput: one request per cycle while requests cause at most one token
//   each and out_stall is low; the output register sends one token per cycle
//   while out_stall is low, and the tokens of one request leave in turn.
//   A four-entry queue absorbs bursts; in_stall rises only when it is full.
//   Reset (synchronous, rst_n low) empties the queue and output register and
//   returns the scanner to idle at byte position zero.
//   While out_stall is high the offered token holds; the scanner keeps taking
//   requests until the queue fills.
//   The end of a text also returns the scanner to position zero.
// ----------------------------------------------------------------------------
module sexpr_token_scanner import sts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_byte_valid,
  input  logic                 in_end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_token_kind,
  output logic [TOK_POS_W-1:0] out_token_start,
  output logic [TOK_LEN_W-1:0] out_token_length,
  output logic [VALUE_W-1:0]   out_number_value,
  output logic                 out_value_overflow,
  output logic                 out_last_of_run
);

  logic    req_take;
  logic    push, pop, empty, full;
  bundle_t push_data, head;
  token_t  out_tok;

  assign in_stall = full;
  assign req_take = in_valid && !full;

  sts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_take     (req_take),
    .text_byte    (in_text_byte),
    .byte_valid   (in_byte_valid),
    .end_of_input (in_end_of_input),
    .push         (push),
    .push_data    (push_data)
  );

  sts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (empty),
    .full      (full),
    .head      (head)
  );

  sts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_tok   (out_tok),
    .out_last  (out_last_of_run)
  );

  assign out_token_kind     = 3'(out_tok.kind);
  assign out_token_start    = out_tok.start;
  assign out_token_length   = out_tok.length;
  assign out_number_value   = out_tok.value;
  assign out_value_overflow = out_tok.overflow;

endmodule
